### hw/rtl/uroa_pkg.sv
package uroa_pkg;

   // default sizes of the tick and echo counters
   localparam int COUNT_BITS_DEF      = 24;
   localparam int ECHO_WIDTH_BITS_DEF = 16;

   // fixed field widths
   localparam int TIMEOUT_W = 16;
   localparam int CM_W      = 10;
   localparam int HOLD_W    = 24;
   localparam int DIST_W    = 21;
   localparam int MOTOR_W   = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   // cm * 1000 needs 20 bits for a 10-bit cm value
   localparam int THR_W        = 20;
   localparam int MILLI_PER_CM = 1000;

   localparam int TRIG_LOW_TICKS  = 2;
   localparam int TRIG_HIGH_TICKS = 10;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TIMEOUT = 3'd0,
      REG_NEAR    = 3'd1,
      REG_SPLIT   = 3'd2,
      REG_FAR     = 3'd3,
      REG_TURN    = 3'd4,
      REG_RUN     = 3'd5
   } reg_idx_type;

   typedef enum logic [1:0] {
      ACT_BRAKE   = 2'd0,
      ACT_FORWARD = 2'd1,
      ACT_LEFT    = 2'd2
   } action_type;

   localparam logic [MOTOR_W-1:0] PAT_OFF     = 4'h0;
   localparam logic [MOTOR_W-1:0] PAT_LEFT    = 4'h8;
   localparam logic [MOTOR_W-1:0] PAT_FORWARD = 4'hA;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 16'd5000;
   localparam logic [CM_W-1:0]      NEAR_RST    = 10'd4;
   localparam logic [CM_W-1:0]      SPLIT_RST   = 10'd30;
   localparam logic [CM_W-1:0]      FAR_RST     = 10'd450;
   localparam logic [HOLD_W-1:0]    TURN_RST    = 24'd300000;
   localparam logic [HOLD_W-1:0]    RUN_RST     = 24'd500000;

endpackage

### hw/rtl/ultrasonic_ranging_obstacle_avoider.sv
// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_ready    req_echo_level
// rsp      out        rsp_valid / rsp_ready    trigger, motors, done, timeout, distance, action
// csr      in         csr_valid / csr_ready    csr_index, csr_data
//
// One item per cycle while rsp_ready keeps the output drained: each item is one 1 us
// tick, and the whole tick's update is done combinationally between the state registers and the rsp output register.
// A new item is taken whenever the output register is empty or being drained.
// Reset is synchronous: trigger-low phase, counters and motors cleared, registers
// back to their defaults. csr writes are always taken and apply at once.
module ultrasonic_ranging_obstacle_avoider
   import uroa_pkg::*;
#(
   parameter int COUNT_BITS      = COUNT_BITS_DEF,
   parameter int ECHO_WIDTH_BITS = ECHO_WIDTH_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_echo_level,

   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic                   rsp_trigger_level,
   output logic [MOTOR_W-1:0]     rsp_motor_lines,
   output logic                   rsp_measure_done,
   output logic                   rsp_timed_out,
   output logic [DIST_W-1:0]      rsp_distance_milli_cm,
   output logic [1:0]             rsp_action,

   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int EW     = ECHO_WIDTH_BITS;
   localparam int D_W    = EW + 5;
   localparam int DCMP_W = (D_W > THR_W) ? D_W : THR_W;
   localparam int WCMP_W = (EW > TIMEOUT_W) ? EW : TIMEOUT_W;
   localparam int HCMP_W = (COUNT_BITS > HOLD_W) ? COUNT_BITS : HOLD_W;

   typedef enum logic [2:0] {
      PH_TRIG_LOW  = 3'd0,
      PH_TRIG_HIGH = 3'd1,
      PH_WAIT_RISE = 3'd2,
      PH_MEASURE   = 3'd3,
      PH_HOLD      = 3'd4
   } phase_type;

   // configuration
   logic [TIMEOUT_W-1:0] timeout_ff;
   logic [CM_W-1:0]      near_ff, split_ff, far_ff;
   logic [HOLD_W-1:0]    turn_ff, run_ff;

   // state
   phase_type            phase_ff, phase_in;
   logic [COUNT_BITS-1:0] tick_ff, tick_in;
   logic [EW-1:0]        width_ff, width_in;
   logic [MOTOR_W-1:0]   motor_ff, motor_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   action_type           action_ff, action_in;

   // output register
   logic                 rsp_valid_ff;
   logic                 trig_ff, trig_in;
   logic                 done_ff, done_in;
   logic                 tout_ff, tout_in;

   logic                  req_fire;
   logic [COUNT_BITS-1:0] tick_inc;
   logic [D_W-1:0]        dist_full;
   logic [THR_W-1:0]      near_thr, split_thr, far_thr;
   logic                  in_left, in_forward;
   logic [HOLD_W-1:0]     hold_len;
   logic [HOLD_W-1:0]     new_len;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   assign tick_inc  = tick_ff + 1'b1;
   // width * 17 = width * 16 + width
   assign dist_full = (D_W'(width_ff) << 4) + D_W'(width_ff);
   assign near_thr  = THR_W'(near_ff)  * THR_W'(MILLI_PER_CM);
   assign split_thr = THR_W'(split_ff) * THR_W'(MILLI_PER_CM);
   assign far_thr   = THR_W'(far_ff)   * THR_W'(MILLI_PER_CM);
   assign in_left    = (DCMP_W'(dist_full) > DCMP_W'(near_thr)) &&
                       (DCMP_W'(dist_full) < DCMP_W'(split_thr));
   assign in_forward = (DCMP_W'(dist_full) > DCMP_W'(split_thr)) &&
                       (DCMP_W'(dist_full) < DCMP_W'(far_thr));
   assign hold_len  = (action_ff == ACT_LEFT) ? turn_ff : run_ff;
   assign new_len   = in_left ? turn_ff : run_ff;

   always_comb begin
      phase_in  = phase_ff;
      tick_in   = tick_ff;
      width_in  = width_ff;
      motor_in  = motor_ff;
      dist_in   = dist_ff;
      action_in = action_ff;
      trig_in   = 1'b0;
      done_in   = 1'b0;
      tout_in   = 1'b0;
      unique case (phase_ff)
         PH_TRIG_LOW: begin
            tick_in = tick_inc;
            if (tick_inc >= COUNT_BITS'(TRIG_LOW_TICKS)) begin
               phase_in = PH_TRIG_HIGH;
               tick_in  = '0;
            end
         end
         PH_TRIG_HIGH: begin
            trig_in = 1'b1;
            tick_in = tick_inc;
            if (tick_inc >= COUNT_BITS'(TRIG_HIGH_TICKS)) begin
               phase_in = PH_WAIT_RISE;
               tick_in  = '0;
            end
         end
         PH_WAIT_RISE: begin
            if (req_echo_level) begin
               if (timeout_ff == '0) begin
                  done_in  = 1'b1;
                  tout_in  = 1'b1;
                  phase_in = PH_TRIG_LOW;
                  tick_in  = '0;
               end else begin
                  width_in = EW'(1);
                  phase_in = PH_MEASURE;
                  tick_in  = '0;
               end
            end else begin
               tick_in = tick_inc;
               if (tick_inc > COUNT_BITS'(timeout_ff) || tick_inc == '0) begin
                  done_in  = 1'b1;
                  tout_in  = 1'b1;
                  phase_in = PH_TRIG_LOW;
                  tick_in  = '0;
               end
            end
         end
         PH_MEASURE: begin
            if (req_echo_level) begin
               if (WCMP_W'(width_ff) >= WCMP_W'(timeout_ff) || &width_ff) begin
                  done_in  = 1'b1;
                  tout_in  = 1'b1;
                  phase_in = PH_TRIG_LOW;
                  tick_in  = '0;
               end else begin
                  width_in = width_ff + 1'b1;
               end
            end else begin
               done_in = 1'b1;
               dist_in = DIST_W'(dist_full);
               tick_in = '0;
               if (in_left || in_forward) begin
                  motor_in  = in_left ? PAT_LEFT : PAT_FORWARD;
                  action_in = in_left ? ACT_LEFT : ACT_FORWARD;
                  // a zero hold goes straight to the next trigger
                  phase_in  = (new_len == '0) ? PH_TRIG_LOW : PH_HOLD;
               end else begin
                  motor_in  = PAT_OFF;
                  action_in = ACT_BRAKE;
                  phase_in  = PH_TRIG_LOW;
               end
            end
         end
         PH_HOLD: begin
            tick_in = tick_inc;
            if (HCMP_W'(tick_inc) >= HCMP_W'(hold_len) || tick_inc == '0) begin
               phase_in = PH_TRIG_LOW;
               tick_in  = '0;
            end
         end
         default: begin
            phase_in = PH_TRIG_LOW;
            tick_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= TIMEOUT_RST;
         near_ff      <= NEAR_RST;
         split_ff     <= SPLIT_RST;
         far_ff       <= FAR_RST;
         turn_ff      <= TURN_RST;
         run_ff       <= RUN_RST;
         phase_ff     <= PH_TRIG_LOW;
         tick_ff      <= '0;
         width_ff     <= '0;
         motor_ff     <= PAT_OFF;
         dist_ff      <= '0;
         action_ff    <= ACT_BRAKE;
         rsp_valid_ff <= 1'b0;
         trig_ff      <= 1'b0;
         done_ff      <= 1'b0;
         tout_ff      <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_TIMEOUT: timeout_ff <= csr_data[TIMEOUT_W-1:0];
               REG_NEAR:    near_ff    <= csr_data[CM_W-1:0];
               REG_SPLIT:   split_ff   <= csr_data[CM_W-1:0];
               REG_FAR:     far_ff     <= csr_data[CM_W-1:0];
               REG_TURN:    turn_ff    <= csr_data[HOLD_W-1:0];
               REG_RUN:     run_ff     <= csr_data[HOLD_W-1:0];
               default: ;
            endcase
         end
         if (req_fire) begin
            phase_ff     <= phase_in;
            tick_ff      <= tick_in;
            width_ff     <= width_in;
            motor_ff     <= motor_in;
            dist_ff      <= dist_in;
            action_ff    <= action_in;
            trig_ff      <= trig_in;
            done_ff      <= done_in;
            tout_ff      <= tout_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // motor, distance and action registers double as the result fields
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_trigger_level     = trig_ff;
   assign rsp_motor_lines       = motor_ff;
   assign rsp_measure_done      = done_ff;
   assign rsp_timed_out         = tout_ff;
   assign rsp_distance_milli_cm = dist_ff;
   assign rsp_action            = action_ff;

`ifndef SYNTH
   a_tout_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_timed_out |-> rsp_measure_done)
      else $error("timeout without measurement end");

   a_trig_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trigger_level |-> !rsp_measure_done)
      else $error("measurement ended during trigger pulse");

   a_pattern: assert property (@(posedge clock) disable iff (reset)
      (action_ff == ACT_LEFT && motor_ff == PAT_LEFT) ||
      (action_ff == ACT_FORWARD && motor_ff == PAT_FORWARD) ||
      (action_ff == ACT_BRAKE && motor_ff == PAT_OFF))
      else $error("motor pattern does not match action");

   a_hold_phase: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HOLD |-> action_ff != ACT_BRAKE)
      else $error("hold phase while braking");
`endif

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import uroa_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE_B = 3'd7;
   localparam int RANDOM_ITEMS = 800;

   typedef enum logic [2:0] {
      ST_TRIG_LOW,
      ST_TRIG_HIGH,
      ST_WAIT_RISE,
      ST_MEASURE,
      ST_HOLD
   } ranger_phase_type;

   typedef struct packed {
      logic               trig;
      logic [MOTOR_W-1:0] motor;
      logic               done;
      logic               tout;
      logic [DIST_W-1:0]  dist_mcm;
      action_type         act;
   } tick_out_type;

   typedef struct {
      bit                    is_cfg;
      logic [CSR_IDX_W-1:0]  idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  echo;
      bit                    typed;
      tick_out_type          want;
   } dir_row_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_echo_level;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_trigger_level;
   logic [MOTOR_W-1:0]    rsp_motor_lines;
   logic                  rsp_measure_done;
   logic                  rsp_timed_out;
   logic [DIST_W-1:0]     rsp_distance_milli_cm;
   logic [1:0]            rsp_action;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   // predictor configuration and state
   logic [TIMEOUT_W-1:0]           cf_timeout;
   logic [CM_W-1:0]                cf_near, cf_split, cf_far;
   logic [HOLD_W-1:0]              cf_turn, cf_run;
   ranger_phase_type               st_phase;
   logic [COUNT_BITS_DEF-1:0]      st_ticks;
   logic [ECHO_WIDTH_BITS_DEF-1:0] st_width;
   logic [MOTOR_W-1:0]             st_motor;
   logic [DIST_W-1:0]              st_dist;
   action_type                     st_act;

   tick_out_type pending_ticks[$];
   dir_row_type  dir_rows[$];
   bit           row_typed;
   tick_out_type row_expect;

   // echo plan for the measurement under way
   bit plan_noise;
   int plan_wait, plan_width, pin_width, wmax;
   bit quiet[2];

   int errors, results_seen, items_sent;
   int meas_total, n_timeouts, n_left, n_fwd, n_brake;

   ultrasonic_ranging_obstacle_avoider u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_echo_level        (req_echo_level),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_trigger_level     (rsp_trigger_level),
      .rsp_motor_lines       (rsp_motor_lines),
      .rsp_measure_done      (rsp_measure_done),
      .rsp_timed_out         (rsp_timed_out),
      .rsp_distance_milli_cm (rsp_distance_milli_cm),
      .rsp_action            (rsp_action),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_data              (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic tick_out_type ranger_tick(input logic echo);
      tick_out_type o;
      logic [HOLD_W-1:0] hold_len;
      logic [31:0] d;
      o = '0;
      case (st_phase)
         ST_TRIG_LOW: begin
            st_ticks = st_ticks + 1'b1;
            if (st_ticks >= TRIG_LOW_TICKS) begin
               st_phase = ST_TRIG_HIGH;
               st_ticks = '0;
            end
         end
         ST_TRIG_HIGH: begin
            o.trig = 1'b1;
            st_ticks = st_ticks + 1'b1;
            if (st_ticks >= TRIG_HIGH_TICKS) begin
               st_phase = ST_WAIT_RISE;
               st_ticks = '0;
            end
         end
         ST_WAIT_RISE: begin
            if (echo) begin
               if (cf_timeout == '0) begin
                  o.done = 1'b1;
                  o.tout = 1'b1;
                  st_phase = ST_TRIG_LOW;
                  st_ticks = '0;
               end else begin
                  // the rise tick already counts as one tick of width
                  st_width = ECHO_WIDTH_BITS_DEF'(1);
                  st_phase = ST_MEASURE;
                  st_ticks = '0;
               end
            end else begin
               st_ticks = st_ticks + 1'b1;
               if (st_ticks > cf_timeout || st_ticks == '0) begin
                  o.done = 1'b1;
                  o.tout = 1'b1;
                  st_phase = ST_TRIG_LOW;
                  st_ticks = '0;
               end
            end
         end
         ST_MEASURE: begin
            if (echo) begin
               if (st_width >= cf_timeout || st_width == '1) begin
                  o.done = 1'b1;
                  o.tout = 1'b1;
                  st_phase = ST_TRIG_LOW;
                  st_ticks = '0;
               end else begin
                  st_width = st_width + 1'b1;
               end
            end else begin
               o.done = 1'b1;
               d = {16'd0, st_width} * 32'd17;
               st_dist = d[DIST_W-1:0];
               if (d > cf_near * 32'd1000 && d < cf_split * 32'd1000) begin
                  st_motor = PAT_LEFT;
                  st_act = ACT_LEFT;
                  st_phase = ST_HOLD;
               end else if (d > cf_split * 32'd1000 && d < cf_far * 32'd1000) begin
                  st_motor = PAT_FORWARD;
                  st_act = ACT_FORWARD;
                  st_phase = ST_HOLD;
               end else begin
                  st_motor = PAT_OFF;
                  st_act = ACT_BRAKE;
                  st_phase = ST_TRIG_LOW;
               end
               st_ticks = '0;
               hold_len = (st_act == ACT_LEFT) ? cf_turn : cf_run;
               if (st_phase == ST_HOLD && hold_len == '0)
                  st_phase = ST_TRIG_LOW;
            end
         end
         ST_HOLD: begin
            // hold length is read live, so a rewrite during a hold applies at once
            hold_len = (st_act == ACT_LEFT) ? cf_turn : cf_run;
            st_ticks = st_ticks + 1'b1;
            if (st_ticks >= hold_len || st_ticks == '0) begin
               st_phase = ST_TRIG_LOW;
               st_ticks = '0;
            end
         end
         default: begin
            st_phase = ST_TRIG_LOW;
            st_ticks = '0;
         end
      endcase
      o.motor = st_motor;
      o.dist_mcm = st_dist;
      o.act = st_act;
      return o;
   endfunction

   function automatic int pick_wait(input int side);
      if ($urandom_range(0, 39) == 0)
         quiet[side] = !quiet[side];
      return quiet[side] ? 0 : $urandom_range(0, 15);
   endfunction

   // echo follows a planned rise delay and pulse width, or noise if so planned; other phases get noise
   function automatic logic pick_echo();
      int lim;
      if (st_phase == ST_WAIT_RISE || st_phase == ST_MEASURE) begin
         if (plan_noise)
            return 1'($urandom_range(0, 1));
         if (st_phase == ST_WAIT_RISE)
            return st_ticks >= plan_wait;
         return st_width < plan_width;
      end
      plan_noise = pin_width == 0 && $urandom_range(0, 7) == 0;
      lim = (cf_timeout < 40) ? cf_timeout : 40;
      plan_wait = $urandom_range(0, lim);
      if (pin_width != 0) begin
         plan_width = pin_width;
      end else begin
         case ($urandom_range(0, 7))
            0: plan_width = (cf_timeout <= 200) ? cf_timeout + 1 : 1;
            1: plan_width = (cf_timeout <= 200) ? cf_timeout : 1;
            default: plan_width = $urandom_range(1, wmax);
         endcase
         if (cf_timeout <= 200 && $urandom_range(0, 7) == 0)
            plan_wait = cf_timeout + 1;
      end
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at result %0d: %s", results_seen, msg);
      errors++;
   endtask

   task automatic check_tick(input tick_out_type seen, input tick_out_type want);
      if (seen.trig !== want.trig)
         report_mismatch($sformatf("trigger_level %0b, expected %0b", seen.trig, want.trig));
      if (seen.motor !== want.motor)
         report_mismatch($sformatf("motor_lines %0h, expected %0h", seen.motor, want.motor));
      if (seen.done !== want.done)
         report_mismatch($sformatf("measure_done %0b, expected %0b", seen.done, want.done));
      if (seen.tout !== want.tout)
         report_mismatch($sformatf("timed_out %0b, expected %0b", seen.tout, want.tout));
      if (seen.dist_mcm !== want.dist_mcm)
         report_mismatch($sformatf("distance_milli_cm %0d, expected %0d",
                                   seen.dist_mcm, want.dist_mcm));
      if (seen.act !== want.act)
         report_mismatch($sformatf("action %0d, expected %0d", seen.act, want.act));
   endtask

   always @(posedge clock) begin
      tick_out_type seen, pred;
      if (reset) begin
         cf_timeout = TIMEOUT_RST;
         cf_near = NEAR_RST;
         cf_split = SPLIT_RST;
         cf_far = FAR_RST;
         cf_turn = TURN_RST;
         cf_run = RUN_RST;
         st_phase = ST_TRIG_LOW;
         st_ticks = '0;
         st_width = '0;
         st_motor = PAT_OFF;
         st_dist = '0;
         st_act = ACT_BRAKE;
         pending_ticks.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.trig = rsp_trigger_level;
            seen.motor = rsp_motor_lines;
            seen.done = rsp_measure_done;
            seen.tout = rsp_timed_out;
            seen.dist_mcm = rsp_distance_milli_cm;
            seen.act = action_type'(rsp_action);
            results_seen++;
            if (pending_ticks.size() == 0)
               report_mismatch("result with no item pending");
            else
               check_tick(seen, pending_ticks.pop_front());
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_TIMEOUT: cf_timeout = csr_data[TIMEOUT_W-1:0];
               REG_NEAR:    cf_near = csr_data[CM_W-1:0];
               REG_SPLIT:   cf_split = csr_data[CM_W-1:0];
               REG_FAR:     cf_far = csr_data[CM_W-1:0];
               REG_TURN:    cf_turn = csr_data[HOLD_W-1:0];
               REG_RUN:     cf_run = csr_data[HOLD_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            pred = ranger_tick(req_echo_level);
            pending_ticks.push_back(row_typed ? row_expect : pred);
            items_sent++;
            if (pred.done) begin
               meas_total++;
               if (pred.tout)
                  n_timeouts++;
               else if (pred.act == ACT_LEFT)
                  n_left++;
               else if (pred.act == ACT_FORWARD)
                  n_fwd++;
               else
                  n_brake++;
            end
         end
      end
   end

   task automatic send_item(input logic echo);
      int n;
      n = pick_wait(0);
      if (n > 0) begin
         req_valid = 1'b0;
         repeat (n) @(negedge clock);
      end
      req_valid = 1'b1;
      req_echo_level = echo;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic settle();
      req_valid = 1'b0;
      while (pending_ticks.size() != 0)
         @(negedge clock);
   endtask

   // leaves csr_valid high; the caller drops it after the last write
   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = data[CSR_DATA_W-1:0];
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic cfg_random();
      logic [TIMEOUT_W-1:0] tmo;
      logic [CM_W-1:0] near_cm, split_cm, far_cm;
      tmo = TIMEOUT_W'($urandom_range(20, 200));
      near_cm = CM_W'($urandom_range(0, 1));
      split_cm = CM_W'($urandom_range(0, 3));
      far_cm = CM_W'($urandom_range(0, 3));
      // upper data bits beyond the register width must be dropped
      csr_write(REG_TIMEOUT, ($urandom & 32'hFF0000) | 32'(tmo));
      csr_write(REG_NEAR, ($urandom & 32'hFFFC00) | 32'(near_cm));
      csr_write(REG_SPLIT, ($urandom & 32'hFFFC00) | 32'(split_cm));
      csr_write(REG_FAR, ($urandom & 32'hFFFC00) | 32'(far_cm));
      csr_write(REG_TURN, $urandom_range(0, 40));
      csr_write(REG_RUN, $urandom_range(0, 40));
      wmax = (far_cm * 59 + 8 > 150) ? 150 : far_cm * 59 + 8;
   endtask

   task automatic add_tick(input logic echo, input bit typed, input logic trig,
                           input logic done, input logic tout,
                           input logic [DIST_W-1:0] dist_mcm);
      dir_row_type r;
      r.is_cfg = 1'b0;
      r.idx = '0;
      r.data = '0;
      r.echo = echo;
      r.typed = typed;
      r.want.trig = trig;
      r.want.motor = PAT_OFF;
      r.want.done = done;
      r.want.tout = tout;
      r.want.dist_mcm = dist_mcm;
      r.want.act = ACT_BRAKE;
      dir_rows.push_back(r);
   endtask

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int n;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         n = pick_wait(1);
         if (n > 0) begin
            rsp_ready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready = 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      dir_row_type cfg_row;
      int n_meas, phases, target;
      bit probe;
      reset = 1'b1;
      req_valid = 1'b0;
      req_echo_level = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      row_typed = 1'b0;
      row_expect = '0;
      pin_width = 0;
      wmax = 60;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // first trigger after reset: two low ticks, ten high ticks
      add_tick(1'b0, 1, 1'b0, 1'b0, 1'b0, 0);
      add_tick(1'b1, 1, 1'b0, 1'b0, 1'b0, 0);
      add_tick(1'b0, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b1, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b0, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b1, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b0, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b1, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b0, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b1, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b0, 1, 1'b1, 1'b0, 1'b0, 0);
      add_tick(1'b1, 1, 1'b1, 1'b0, 1'b0, 0);
      // echo rises at once, one-tick pulse: 17 milli-cm, below near bound, brake
      add_tick(1'b1, 1, 1'b0, 1'b0, 1'b0, 0);
      add_tick(1'b0, 1, 1'b0, 1'b1, 1'b0, 17);
      // zero timeout: next measurement fails on the first wait tick
      cfg_row.is_cfg = 1'b1;
      cfg_row.idx = REG_TIMEOUT;
      cfg_row.data = '0;
      cfg_row.echo = 1'b0;
      cfg_row.typed = 1'b0;
      cfg_row.want = '0;
      dir_rows.push_back(cfg_row);
      for (int i = 0; i < 12; i++)
         add_tick(i[0], 0, 1'b0, 1'b0, 1'b0, 0);
      add_tick(1'b0, 1, 1'b0, 1'b1, 1'b1, 17);
      add_tick(1'b1, 0, 1'b0, 1'b0, 1'b0, 0);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_cfg) begin
            settle();
            csr_write(dir_rows[i].idx, 32'(dir_rows[i].data));
            csr_valid = 1'b0;
         end else begin
            row_typed = dir_rows[i].typed;
            row_expect = dir_rows[i].want;
            send_item(dir_rows[i].echo);
         end
      end
      row_typed = 1'b0;

      // every special setting runs once; the bound check alone needs a 1000-tick pulse
      phases = 0;
      while (phases < 6 || items_sent < RANDOM_ITEMS) begin
         settle();
         n_meas = $urandom_range(1, 3);
         probe = 0;
         case (phases)
            0: begin
               // distance lands exactly on the split bound: brake
               csr_write(REG_TIMEOUT, 1100);
               csr_write(REG_NEAR, 0);
               csr_write(REG_SPLIT, 17);
               csr_write(REG_FAR, 18);
               csr_write(REG_TURN, $urandom_range(0, 40));
               csr_write(REG_RUN, $urandom_range(0, 40));
               pin_width = 1000;
               n_meas = 1;
            end
            1: begin
               cfg_random();
               csr_write(REG_TURN, 0);
               csr_write(REG_RUN, 0);
            end
            2: begin
               // every good distance drives forward; hold is cut short later
               cfg_random();
               csr_write(REG_NEAR, 0);
               csr_write(REG_SPLIT, 0);
               csr_write(REG_FAR, 1023);
               csr_write(REG_TURN, 32'hFFFFFF);
               csr_write(REG_RUN, 32'hFFFFFF);
               wmax = 60;
               probe = 1;
            end
            3: begin
               csr_write(REG_TIMEOUT, 0);
               csr_write(REG_NEAR, 1023);
               csr_write(REG_SPLIT, 1023);
               csr_write(REG_FAR, 1023);
               csr_write(REG_TURN, 32'hFFFFFF);
               csr_write(REG_RUN, 0);
            end
            4: begin
               csr_write(REG_TIMEOUT, 32'hFFFF);
               csr_write(REG_NEAR, 0);
               csr_write(REG_SPLIT, 0);
               csr_write(REG_FAR, 1023);
               csr_write(REG_TURN, 0);
               csr_write(REG_RUN, $urandom_range(0, 40));
               wmax = 60;
            end
            5: begin
               cfg_random();
               csr_write(REG_SPARE_A, $urandom);
               csr_write(REG_SPARE_B, $urandom);
            end
            default: cfg_random();
         endcase
         csr_valid = 1'b0;
         if (probe) begin
            while (!(st_phase == ST_HOLD && st_ticks >= 20))
               send_item(pick_echo());
            settle();
            csr_write(REG_RUN, $urandom_range(0, 40));
            csr_write(REG_TURN, $urandom_range(0, 40));
            csr_valid = 1'b0;
         end
         target = meas_total + n_meas;
         while (meas_total < target)
            send_item(pick_echo());
         pin_width = 0;
         phases++;
      end

      settle();
      repeat (10) @(posedge clock);
      $display("run covered %0d items and %0d results over %0d register settings",
               items_sent, results_seen, phases + 1);
      $display("measurements %0d: %0d timed out, %0d turn left, %0d forward, %0d brake",
               meas_total, n_timeouts, n_left, n_fwd, n_brake);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

### ultrasonic_ranging_obstacle_avoider.f
hw/rtl/uroa_pkg.sv
hw/rtl/ultrasonic_ranging_obstacle_avoider.sv
test/testbench.sv
